[hdl/obs_pkg.sv]
// Shared constants and types for the oriented box versus sphere overlap test.
package obs_pkg;

  // Lanes per packed register (x, y, z from low to high)
  localparam int LANE_COUNT = 3;

  // Fixed width of the radius field
  localparam int RADIUS_BITS = 15;

  // Configuration index width and register indexes
  localparam int CFG_INDEX_BITS = 3;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_BOX_CENTER   = 3'd0;
  localparam cfg_index_t REG_AXIS_FIRST   = 3'd1;
  localparam cfg_index_t REG_AXIS_SECOND  = 3'd2;
  localparam cfg_index_t REG_AXIS_THIRD   = 3'd3;
  localparam cfg_index_t REG_HALF_EXTENTS = 3'd4;

  // Entries in the queue between front and back (power of two)
  localparam int QUEUE_DEPTH = 4;

endpackage

[hdl/obs_front.sv]
// Front part: projects the sphere offset onto the box axes and forms per-axis excesses.
module obs_front #(
  parameter int COORD_BITS         = 16,
  parameter int AXIS_FRACTION_BITS = 14,
  parameter int QW                 = 1 + obs_pkg::RADIUS_BITS
                                     + 3 * (obs_pkg::RADIUS_BITS + AXIS_FRACTION_BITS)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [3*COORD_BITS-1:0]           box_center,
  input  logic [3*COORD_BITS-1:0]           axis_first,
  input  logic [3*COORD_BITS-1:0]           axis_second,
  input  logic [3*COORD_BITS-1:0]           axis_third,
  input  logic [3*COORD_BITS-1:0]           half_extents,
  input  logic                              sphere_valid,
  output logic                              sphere_ready,
  input  logic signed [COORD_BITS-1:0]      sphere_x,
  input  logic signed [COORD_BITS-1:0]      sphere_y,
  input  logic signed [COORD_BITS-1:0]      sphere_z,
  input  logic [obs_pkg::RADIUS_BITS-1:0]   sphere_radius,
  output logic                              q_valid,
  input  logic                              q_ready,
  output logic [QW-1:0]                     q_data
);
  import obs_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = AXIS_FRACTION_BITS;
  localparam int DW = C + 1;
  localparam int PW = 2 * C + 1;
  localparam int SW = 2 * C + 3;
  localparam int EW = C + F;
  localparam int RW = RADIUS_BITS + F;
  localparam int XA = (SW > EW + 1) ? SW : EW + 1;
  localparam int XW = (XA > RW + 1) ? XA : RW + 1;

  // Stage valid bits and ready chain
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic r1, r2, r3, r4;

  assign r4 = !s4_valid || q_ready;
  assign r3 = !s3_valid || r4;
  assign r2 = !s2_valid || r3;
  assign r1 = !s1_valid || r2;
  assign sphere_ready = r1;
  assign q_valid = s4_valid;

  // Stage payloads
  logic signed [DW-1:0]   s1_diff [LANE_COUNT];
  logic [RADIUS_BITS-1:0] s1_rad;
  logic signed [PW-1:0]   s2_prod [LANE_COUNT*LANE_COUNT];
  logic [RADIUS_BITS-1:0] s2_rad;
  logic [SW-1:0]          s3_mag [LANE_COUNT];
  logic [RADIUS_BITS-1:0] s3_rad;
  logic                   s4_far;
  logic [RW-1:0]          s4_d [LANE_COUNT];
  logic [RADIUS_BITS-1:0] s4_rad;

  // Combinational results feeding each stage
  logic signed [C-1:0]    sph [LANE_COUNT];
  logic signed [DW-1:0]   diff_next [LANE_COUNT];
  logic [3*C-1:0]         axes [LANE_COUNT];
  logic signed [PW-1:0]   prod_next [LANE_COUNT*LANE_COUNT];
  logic signed [SW-1:0]   proj [LANE_COUNT];
  logic [SW-1:0]          mag_next [LANE_COUNT];
  logic [XW-1:0]          mag_x [LANE_COUNT];
  logic [XW-1:0]          ext_x [LANE_COUNT];
  logic [XW-1:0]          excess [LANE_COUNT];
  logic [XW-1:0]          rad_x;
  logic [LANE_COUNT-1:0]  over;
  logic [LANE_COUNT-1:0]  far_lane;
  logic [RW-1:0]          d_next [LANE_COUNT];

  assign sph[0]  = sphere_x;
  assign sph[1]  = sphere_y;
  assign sph[2]  = sphere_z;
  assign axes[0] = axis_first;
  assign axes[1] = axis_second;
  assign axes[2] = axis_third;

  // Offset from box center to sphere center
  always_comb begin
    for (int k = 0; k < LANE_COUNT; k++) begin
      diff_next[k] = DW'(sph[k]) - DW'($signed(box_center[k*C +: C]));
    end
  end

  // One product per axis lane and coordinate lane pair
  always_comb begin
    for (int i = 0; i < LANE_COUNT; i++) begin
      for (int k = 0; k < LANE_COUNT; k++) begin
        prod_next[i*LANE_COUNT+k] = PW'(s1_diff[k]) * PW'($signed(axes[i][k*C +: C]));
      end
    end
  end

  // Sum the products and take the magnitude
  always_comb begin
    for (int i = 0; i < LANE_COUNT; i++) begin
      proj[i] = SW'(s2_prod[i*LANE_COUNT]) + SW'(s2_prod[i*LANE_COUNT+1])
              + SW'(s2_prod[i*LANE_COUNT+2]);
      mag_next[i] = proj[i][SW-1] ? SW'(-proj[i]) : SW'(proj[i]);
    end
  end

  // Excess over each half extent, flagged far when beyond the radius
  always_comb begin
    rad_x = XW'({s3_rad, {F{1'b0}}});
    for (int i = 0; i < LANE_COUNT; i++) begin
      mag_x[i]    = XW'(s3_mag[i]);
      ext_x[i]    = XW'({half_extents[i*C +: C], {F{1'b0}}});
      over[i]     = mag_x[i] > ext_x[i];
      excess[i]   = mag_x[i] - ext_x[i];
      far_lane[i] = over[i] && (excess[i] > rad_x);
      d_next[i]   = (over[i] && !far_lane[i]) ? excess[i][RW-1:0] : '0;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (r1) s1_valid <= sphere_valid;
      if (r2) s2_valid <= s1_valid;
      if (r3) s3_valid <= s2_valid;
      if (r4) s4_valid <= s3_valid;
    end
  end

  // Advance payloads
  always_ff @(posedge clk) begin
    if (r1 && sphere_valid) begin
      s1_diff <= diff_next;
      s1_rad  <= sphere_radius;
    end
    if (r2 && s1_valid) begin
      s2_prod <= prod_next;
      s2_rad  <= s1_rad;
    end
    if (r3 && s2_valid) begin
      s3_mag <= mag_next;
      s3_rad <= s2_rad;
    end
    if (r4 && s3_valid) begin
      s4_far <= |far_lane;
      s4_d   <= d_next;
      s4_rad <= s3_rad;
    end
  end

  assign q_data = {s4_far, s4_rad, s4_d[2], s4_d[1], s4_d[0]};

endmodule

[hdl/obs_queue.sv]
// Short first-in first-out queue between the front and back parts.
module obs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  // Depth is a power of two so the pointers wrap on their own
  localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PB-1:0]    wr_ptr;
  logic [PB-1:0]    rd_ptr;
  logic [CB-1:0]    count;
  logic             push;
  logic             pop;

  assign push_ready = count != CB'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  // Move pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Store an item
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

[hdl/obs_back.sv]
// Back part: squares the excesses and compares their sum with the squared radius.
module obs_back #(
  parameter int AXIS_FRACTION_BITS = 14,
  parameter int QW                 = 1 + obs_pkg::RADIUS_BITS
                                     + 3 * (obs_pkg::RADIUS_BITS + AXIS_FRACTION_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [QW-1:0] q_data,
  output logic          result_valid,
  input  logic          result_ready,
  output logic          hit
);
  import obs_pkg::*;

  localparam int F  = AXIS_FRACTION_BITS;
  localparam int RW = RADIUS_BITS + F;
  localparam int QQ = 2 * RW;
  localparam int TW = 2 * RW + 2;

  // Unpack the queue item
  logic                   q_far;
  logic [RADIUS_BITS-1:0] q_rad;
  logic [RW-1:0]          q_d [LANE_COUNT];
  logic [RW-1:0]          q_rad_s;

  assign q_far   = q_data[QW-1];
  assign q_rad   = q_data[3*RW +: RADIUS_BITS];
  assign q_d[0]  = q_data[0 +: RW];
  assign q_d[1]  = q_data[RW +: RW];
  assign q_d[2]  = q_data[2*RW +: RW];
  assign q_rad_s = {q_rad, {F{1'b0}}};

  // Ready chain
  logic b1_valid;
  logic rb1, rb2;

  assign rb2          = !result_valid || result_ready;
  assign rb1          = !b1_valid || rb2;
  assign q_ready      = rb1;

  // Square stage
  logic [QQ-1:0] b1_sq [LANE_COUNT];
  logic [QQ-1:0] b1_rad_sq;
  logic          b1_far;
  logic [TW-1:0] sum;

  assign sum = TW'(b1_sq[0]) + TW'(b1_sq[1]) + TW'(b1_sq[2]);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rb1) b1_valid     <= q_valid;
      if (rb2) result_valid <= b1_valid;
    end
  end

  // Square, then sum and compare
  always_ff @(posedge clk) begin
    if (rb1 && q_valid) begin
      for (int i = 0; i < LANE_COUNT; i++) begin
        b1_sq[i] <= QQ'(q_d[i]) * QQ'(q_d[i]);
      end
      b1_rad_sq <= QQ'(q_rad_s) * QQ'(q_rad_s);
      b1_far    <= q_far;
    end
    if (rb2 && b1_valid) begin
      hit <= !b1_far && (sum <= TW'(b1_rad_sq));
    end
  end

endmodule

[hdl/oriented_box_sphere_overlap_test.sv]
// Top level: configuration registers, front projection pipe, queue and back compare pipe.
// Each sphere passes through the four front stages, the queue and the two back stages to hit.
// Throughput: one sphere per cycle while the output is not stalled; every stage of the four-stage
// front pipe and the two-stage back pipe then takes a new item each cycle, multipliers in one stage of each.
// A four-entry queue between the parts absorbs output stalls.
// Reset (synchronous): clears all valid bits and the queue; axes return to identity,
// box center and half extents to zero. No clearing pass is needed.
module oriented_box_sphere_overlap_test #(
  parameter int COORD_BITS         = 16,
  parameter int AXIS_FRACTION_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  obs_pkg::cfg_index_t               write_index,
  input  logic [3*COORD_BITS-1:0]           write_data,
  input  logic                              sphere_valid,
  output logic                              sphere_ready,
  input  logic signed [COORD_BITS-1:0]      sphere_x,
  input  logic signed [COORD_BITS-1:0]      sphere_y,
  input  logic signed [COORD_BITS-1:0]      sphere_z,
  input  logic [obs_pkg::RADIUS_BITS-1:0]   sphere_radius,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic                              hit
);
  import obs_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = AXIS_FRACTION_BITS;
  localparam int RW = RADIUS_BITS + F;
  localparam int QW = 1 + RADIUS_BITS + 3 * RW;

  localparam logic [C-1:0] UNIT = C'(1) << F;

  logic [3*C-1:0] box_center;
  logic [3*C-1:0] axis_first;
  logic [3*C-1:0] axis_second;
  logic [3*C-1:0] axis_third;
  logic [3*C-1:0] half_extents;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      box_center   <= '0;
      axis_first   <= {{C{1'b0}}, {C{1'b0}}, UNIT};
      axis_second  <= {{C{1'b0}}, UNIT, {C{1'b0}}};
      axis_third   <= {UNIT, {C{1'b0}}, {C{1'b0}}};
      half_extents <= '0;
    end else if (write_enable) begin
      case (write_index)
        REG_BOX_CENTER:   box_center   <= write_data;
        REG_AXIS_FIRST:   axis_first   <= write_data;
        REG_AXIS_SECOND:  axis_second  <= write_data;
        REG_AXIS_THIRD:   axis_third   <= write_data;
        REG_HALF_EXTENTS: half_extents <= write_data;
        default: ;
      endcase
    end
  end

  logic          fq_valid, fq_ready;
  logic [QW-1:0] fq_data;
  logic          qb_valid, qb_ready;
  logic [QW-1:0] qb_data;

  obs_front #(
    .COORD_BITS         (C),
    .AXIS_FRACTION_BITS (F),
    .QW                 (QW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .box_center    (box_center),
    .axis_first    (axis_first),
    .axis_second   (axis_second),
    .axis_third    (axis_third),
    .half_extents  (half_extents),
    .sphere_valid  (sphere_valid),
    .sphere_ready  (sphere_ready),
    .sphere_x      (sphere_x),
    .sphere_y      (sphere_y),
    .sphere_z      (sphere_z),
    .sphere_radius (sphere_radius),
    .q_valid       (fq_valid),
    .q_ready       (fq_ready),
    .q_data        (fq_data)
  );

  obs_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  obs_back #(
    .AXIS_FRACTION_BITS (F),
    .QW                 (QW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (qb_valid),
    .q_ready      (qb_ready),
    .q_data       (qb_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .hit          (hit)
  );

endmodule

[hdl/obs_checker.sv]
// Port-level checker for the overlap test, bound to the top level.
module obs_checker (
  input logic clk,
  input logic rst,
  input logic sphere_valid,
  input logic sphere_ready,
  input logic result_valid,
  input logic result_ready,
  input logic hit
);
  import obs_pkg::*;

  // Front stages, queue entries and back stages
  localparam int CAPACITY = 4 + QUEUE_DEPTH + 2;
  localparam int NB       = $clog2(CAPACITY + 2);

  logic [NB-1:0] pending;
  logic          acc_in, acc_out;

  assign acc_in  = sphere_valid && sphere_ready;
  assign acc_out = result_valid && result_ready;

  // Track items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (acc_in && !acc_out) begin
      pending <= pending + 1'b1;
    end else if (acc_out && !acc_in) begin
      pending <= pending - 1'b1;
    end
  end

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(hit))
    else $error("stalled result changed");

  // No result without an item in flight
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != '0)
    else $error("result with no item outstanding");

  // Items in flight never exceed the pipe capacity
  a_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= NB'(CAPACITY))
    else $error("more items in flight than storage");

  // Reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind oriented_box_sphere_overlap_test obs_checker u_obs_checker (
  .clk          (clk),
  .rst          (rst),
  .sphere_valid (sphere_valid),
  .sphere_ready (sphere_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .hit          (hit)
);

[dv/tb_top.sv]
// Self-checking testbench for the oriented box versus sphere overlap test.
module tb_top;
  import obs_pkg::*;

  localparam int COORD_BITS      = 16;
  localparam int AXIS_FRAC       = 14;
  localparam int REG_BITS        = 3 * COORD_BITS;
  localparam int REG_COUNT       = int'(REG_HALF_EXTENTS) + 1;
  localparam int PIPE_LATENCY    = 6;
  localparam int SETTLE_CYCLES   = PIPE_LATENCY + 6;
  localparam int LONG_HOLD       = 200;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 128;
  localparam int LIMIT_TIME      = 1200000;

  // Q8.8 and Q2.14 constants
  localparam int ONE       = 'h0100;
  localparam int AXIS_ONE  = 'h4000;
  localparam int AXIS_DIAG = 11585;
  localparam int AXIS_COS  = 14189;
  localparam int AXIS_SIN  = 8192;
  localparam int LANE_MAX  = 32767;
  localparam int LANE_MIN  = -32768;
  localparam int RAD_MAX   = 32767;

  typedef enum logic [1:0] {GAPS_BOTH, GAPS_NONE, GAPS_SENDER, GAPS_RECEIVER} gap_mode_t;

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic [RADIUS_BITS-1:0]       radius;
  } sphere_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          write_enable = 1'b0;
  cfg_index_t                    write_index = REG_BOX_CENTER;
  logic [REG_BITS-1:0]           write_data = '0;
  logic                          sphere_valid = 1'b0;
  logic                          sphere_ready;
  logic signed [COORD_BITS-1:0]  sphere_x = '0;
  logic signed [COORD_BITS-1:0]  sphere_y = '0;
  logic signed [COORD_BITS-1:0]  sphere_z = '0;
  logic [RADIUS_BITS-1:0]        sphere_radius = '0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  logic                          hit;

  // Box settings as last written, spheres waiting to go, predicted hit flags
  logic [REG_BITS-1:0] box_regs [REG_COUNT];
  sphere_t             sphere_pending [$];
  logic                hit_expect [$];
  sphere_t             offered;
  gap_mode_t           gap_mode = GAPS_BOTH;
  int                  spheres_queued = 0;
  int                  spheres_sent = 0;
  int                  results_seen = 0;
  int                  hits_seen = 0;
  int                  errors = 0;
  int                  settings_used = 0;
  int                  send_gap = 0;
  int                  recv_stall = 0;
  logic                long_hold_done = 1'b0;

  oriented_box_sphere_overlap_test #(
    .COORD_BITS        (COORD_BITS),
    .AXIS_FRACTION_BITS(AXIS_FRAC)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .sphere_valid (sphere_valid),
    .sphere_ready (sphere_ready),
    .sphere_x     (sphere_x),
    .sphere_y     (sphere_y),
    .sphere_z     (sphere_z),
    .sphere_radius(sphere_radius),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .hit          (hit)
  );

  always #1 clk = ~clk;

  function automatic int lane(logic [REG_BITS-1:0] r, int k);
    return int'($signed(r[COORD_BITS*k +: COORD_BITS]));
  endfunction

  function automatic logic [REG_BITS-1:0] pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic int rand_offset(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [REG_BITS-1:0] rand_reg();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Project the center offset on each box axis and sum the squared excesses
  function automatic logic overlap_hit(sphere_t s);
    longint              coord [3];
    longint              offset [3];
    longint              proj, mag, ext, excess, rad;
    longint unsigned     excess_sq;
    logic                touch;
    logic [REG_BITS-1:0] axis;
    coord[0] = longint'(s.x);
    coord[1] = longint'(s.y);
    coord[2] = longint'(s.z);
    rad = longint'(s.radius) << AXIS_FRAC;
    excess_sq = 0;
    touch = 1'b1;
    for (int k = 0; k < 3; k++)
      offset[k] = coord[k] - longint'(lane(box_regs[REG_BOX_CENTER], k));
    for (int a = 0; a < 3; a++) begin
      axis = box_regs[int'(REG_AXIS_FIRST) + a];
      proj = 0;
      for (int k = 0; k < 3; k++)
        proj += offset[k] * longint'(lane(axis, k));
      mag = (proj < 0) ? -proj : proj;
      ext = longint'(box_regs[REG_HALF_EXTENTS][COORD_BITS*a +: COORD_BITS]) << AXIS_FRAC;
      if (mag > ext) begin
        excess = mag - ext;
        if (excess > rad) touch = 1'b0;
        else excess_sq += longint'(excess * excess);
      end
    end
    if (touch && excess_sq > longint'(rad * rad)) touch = 1'b0;
    return touch;
  endfunction

  task automatic queue_sphere(int x, int y, int z, int r);
    sphere_t s;
    s.x = 16'(x);
    s.y = 16'(y);
    s.z = 16'(z);
    s.radius = 15'(r);
    sphere_pending.push_back(s);
    spheres_queued++;
  endtask

  // Mostly spheres placed around the box, some with fully random fields
  task automatic queue_random_sphere();
    int pick, span, cx, cy, cz;
    pick = $urandom_range(0, 9);
    cx = lane(box_regs[REG_BOX_CENTER], 0);
    cy = lane(box_regs[REG_BOX_CENTER], 1);
    cz = lane(box_regs[REG_BOX_CENTER], 2);
    if (pick < 3) begin
      queue_sphere($urandom, $urandom, $urandom, $urandom);
    end else begin
      span = (pick < 6) ? 'h0400 : ((pick < 9) ? 'h1000 : 'h6000);
      queue_sphere(cx + rand_offset(span), cy + rand_offset(span), cz + rand_offset(span),
                   (pick < 7) ? $urandom_range(0, 'h0800) : $urandom);
    end
  endtask

  // Write one register; the mirror drops indexes the block ignores
  task automatic cfg_write(cfg_index_t idx, logic [REG_BITS-1:0] data);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= data;
    if (int'(idx) < REG_COUNT) box_regs[idx] = data;
    @(posedge clk);
  endtask

  task automatic write_box(logic [REG_BITS-1:0] center, logic [REG_BITS-1:0] a1,
                           logic [REG_BITS-1:0] a2, logic [REG_BITS-1:0] a3,
                           logic [REG_BITS-1:0] half);
    cfg_write(REG_BOX_CENTER, center);
    cfg_write(REG_AXIS_FIRST, a1);
    cfg_write(REG_AXIS_SECOND, a2);
    cfg_write(REG_AXIS_THIRD, a3);
    cfg_write(REG_HALF_EXTENTS, half);
    settings_used++;
  endtask

  task automatic load_setting(int p);
    case (p)
      0: write_box(pack3(rand_offset('h0800), rand_offset('h0800), rand_offset('h0800)),
                   pack3(AXIS_DIAG, AXIS_DIAG, 0), pack3(-AXIS_DIAG, AXIS_DIAG, 0),
                   pack3(0, 0, AXIS_ONE),
                   pack3($urandom_range(0, 'h0800), $urandom_range(0, 'h0800),
                         $urandom_range(0, 'h0800)));
      1: write_box(pack3(rand_offset('h4000), rand_offset('h4000), rand_offset('h4000)),
                   pack3(AXIS_ONE, 0, 0), pack3(0, AXIS_ONE, 0), pack3(0, 0, AXIS_ONE),
                   pack3($urandom_range(0, 'h1000), $urandom_range(0, 'h1000),
                         $urandom_range(0, 'h1000)));
      2: write_box(pack3(LANE_MAX, LANE_MIN, LANE_MAX), pack3(LANE_MIN, LANE_MIN, LANE_MIN),
                   pack3(LANE_MIN, LANE_MIN, LANE_MIN), pack3(LANE_MIN, LANE_MIN, LANE_MIN),
                   pack3(-1, -1, -1));
      3: write_box('1, '1, '1, '1, '1);
      4: write_box('0, '0, '0, '0, '0);
      5: write_box(pack3(LANE_MIN, LANE_MIN, LANE_MIN), pack3(LANE_MAX, LANE_MAX, LANE_MAX),
                   pack3(LANE_MAX, LANE_MAX, LANE_MAX), pack3(LANE_MAX, LANE_MAX, LANE_MAX),
                   '0);
      6: begin
        write_box(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
        // Writes to unused indexes must leave the box alone
        for (int i = REG_COUNT; i < 2 ** CFG_INDEX_BITS; i++)
          cfg_write(cfg_index_t'(i), rand_reg());
      end
      7: write_box(pack3(rand_offset('h1000), rand_offset('h1000), rand_offset('h1000)),
                   pack3(AXIS_ONE, 0, 0), pack3(0, AXIS_COS, AXIS_SIN),
                   pack3(0, -AXIS_SIN, AXIS_COS),
                   pack3($urandom_range(0, 'h0600), $urandom_range(0, 'h0600),
                         $urandom_range(0, 'h0600)));
      default: write_box(pack3(rand_offset('h2000), rand_offset('h2000), rand_offset('h2000)),
                         pack3(rand_offset('h4000), rand_offset('h4000), rand_offset('h4000)),
                         pack3(rand_offset('h4000), rand_offset('h4000), rand_offset('h4000)),
                         pack3(rand_offset('h4000), rand_offset('h4000), rand_offset('h4000)),
                         pack3($urandom_range(0, 'h2000), $urandom_range(0, 'h2000),
                               $urandom_range(0, 'h2000)));
    endcase
    write_enable <= 1'b0;
  endtask

  // Wait until every queued sphere has been accepted and answered, then let the pipe settle
  task automatic wait_drained();
    @(posedge clk);
    while (spheres_sent != spheres_queued || results_seen != spheres_queued)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer queued spheres and predict each accepted one
  always @(posedge clk) begin
    if (rst) begin
      sphere_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (sphere_valid && sphere_ready) begin
        hit_expect.push_back(overlap_hit(offered));
        spheres_sent++;
      end
      if (!sphere_valid || sphere_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          sphere_valid <= 1'b0;
        end else if (sphere_pending.size() > 0) begin
          offered = sphere_pending.pop_front();
          sphere_x <= offered.x;
          sphere_y <= offered.y;
          sphere_z <= offered.z;
          sphere_radius <= offered.radius;
          sphere_valid <= 1'b1;
          if (gap_mode == GAPS_BOTH || gap_mode == GAPS_SENDER) send_gap = pick_gap();
        end else begin
          sphere_valid <= 1'b0;
        end
      end
    end
  end

  // Check each result against the oldest prediction and pace result_ready
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (hit_expect.size() == 0) begin
          $display("%0t: result with nothing expected, hit=%0b", $time, hit);
          errors++;
        end else begin
          if (hit !== hit_expect[0]) begin
            $display("%0t: hit mismatch, expected %0b actual %0b", $time, hit_expect[0], hit);
            errors++;
          end
          void'(hit_expect.pop_front());
        end
        if (hit === 1'b1) hits_seen++;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        result_ready <= 1'b0;
      end else if (gap_mode == GAPS_NONE && !long_hold_done) begin
        // Hold off long enough for the block to fill and stall its input
        long_hold_done = 1'b1;
        recv_stall = LONG_HOLD;
        result_ready <= 1'b0;
      end else if (gap_mode == GAPS_BOTH || gap_mode == GAPS_RECEIVER) begin
        recv_stall = pick_gap();
        result_ready <= (recv_stall == 0);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  initial begin
    box_regs[REG_BOX_CENTER]   = '0;
    box_regs[REG_AXIS_FIRST]   = pack3(AXIS_ONE, 0, 0);
    box_regs[REG_AXIS_SECOND]  = pack3(0, AXIS_ONE, 0);
    box_regs[REG_AXIS_THIRD]   = pack3(0, 0, AXIS_ONE);
    box_regs[REG_HALF_EXTENTS] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset box: a point at the origin; field extremes, touching and corner cases
    @(negedge clk);
    queue_sphere(0, 0, 0, 0);
    queue_sphere(ONE, 0, 0, ONE);
    queue_sphere(ONE, 0, 0, ONE - 1);
    queue_sphere(LANE_MAX, LANE_MAX, LANE_MAX, RAD_MAX);
    queue_sphere(LANE_MIN, LANE_MIN, LANE_MIN, RAD_MAX);
    queue_sphere(LANE_MIN, 0, 0, RAD_MAX);
    queue_sphere(LANE_MAX, 0, 0, RAD_MAX);
    queue_sphere(0, 0, 0, RAD_MAX);
    wait_drained();

    // Cube of half extent one off the origin: inside, face, edge, corner and large excess
    write_box(pack3(ONE, -2 * ONE, ONE / 2), pack3(AXIS_ONE, 0, 0), pack3(0, AXIS_ONE, 0),
              pack3(0, 0, AXIS_ONE), pack3(ONE, ONE, ONE));
    write_enable <= 1'b0;
    @(negedge clk);
    queue_sphere(ONE, -2 * ONE, ONE / 2, 0);
    queue_sphere(3 * ONE, -2 * ONE, ONE / 2, ONE);
    queue_sphere(3 * ONE, -2 * ONE, ONE / 2, ONE - 1);
    queue_sphere(ONE, -2 * ONE, ONE / 2 - 3 * ONE, 2 * ONE);
    queue_sphere(5 * ONE, 3 * ONE, ONE / 2, 5 * ONE);
    queue_sphere(5 * ONE, 3 * ONE, ONE / 2, 5 * ONE - 1);
    queue_sphere(-ONE, ONE, ONE / 2 - 3 * ONE, 3 * ONE);
    queue_sphere(-ONE, ONE, ONE / 2 - 3 * ONE, 3 * ONE - 1);
    queue_sphere(10 * ONE, 0, ONE / 2, 4 * ONE);
    wait_drained();

    // Random spheres over a series of box settings and idling patterns
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gap_mode <= gap_mode_t'(p % 4);
      load_setting(p);
      @(negedge clk);
      repeat (ITEMS_PER_PHASE) queue_random_sphere();
      wait_drained();
    end

    $display("Checked %0d spheres against %0d box settings plus reset: %0d hits, %0d misses.",
             results_seen, settings_used, hits_seen, results_seen - hits_seen);
    $display("Idling on both sides and one receiver hold-off of %0d cycles were exercised.",
             LONG_HOLD);
    if (errors == 0 && hit_expect.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Bound the run in case the handshake hangs
  initial begin
    #LIMIT_TIME;
    $display("Timeout with %0d of %0d spheres answered.", results_seen, spheres_queued);
    $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
hdl/obs_pkg.sv
hdl/obs_front.sv
hdl/obs_queue.sv
hdl/obs_back.sv
hdl/oriented_box_sphere_overlap_test.sv
hdl/obs_checker.sv
dv/tb_top.sv
